>>> design/lmtc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lmtc_pkg
// Shared widths, register indexes and mode bits of the lightmap texel
// color block.
// ---------------------------------------------------------------------------
package lmtc_pkg;

	localparam int LEVEL_W           = 4;
	localparam int COLOR_W           = 8;
	localparam int Q_W               = 16;
	localparam int CFG_DATA_W        = 64;
	localparam int CFG_IDX_W         = 3;
	localparam int TABLE_ENTRIES     = 16;
	localparam int FRACTION_BITS_DEF = 15;
	localparam int NUM_CH            = 3;
	localparam int NSTAGE            = 12;

	localparam int CH_RED   = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 2;

	// Bit positions inside the mode register.
	localparam int MODE_LIGHTNING = 0;
	localparam int MODE_END       = 1;
	localparam int MODE_W         = 2;

	localparam logic [Q_W-1:0] SUN_RESET = 16'h8000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SUN     = 3'd0,
		REG_GAMMA   = 3'd1,
		REG_FLICKER = 3'd2,
		REG_MODE    = 3'd3,
		REG_TABLE_A = 3'd4,
		REG_TABLE_B = 3'd5,
		REG_TABLE_C = 3'd6,
		REG_TABLE_D = 3'd7
	} cfg_reg_t;

endpackage

>>> design/lmtc_intf.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lmtc_intf
// Valid/ready channels of the lightmap texel color block: light levels in,
// texel color out.
// ---------------------------------------------------------------------------
interface lmtc_level_if import lmtc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [LEVEL_W-1:0] sky_level;
	logic [LEVEL_W-1:0] block_level;

	modport source(output valid, sky_level, block_level, input ready);
	modport sink(input valid, sky_level, block_level, output ready);
endinterface

interface lmtc_color_if import lmtc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COLOR_W-1:0] red;
	logic [COLOR_W-1:0] green;
	logic [COLOR_W-1:0] blue;

	modport source(output valid, red, green, blue, input ready);
	modport sink(input valid, red, green, blue, output ready);
endinterface

>>> design/lightmap_texel_color.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lightmap_texel_color
// Computes the red, green and blue of one light map texel from a sky level
// and a block level.
// ---------------------------------------------------------------------------
// Usage: an item on the levels channel carries a sky level and a block
// level; each indexes the 16-entry brightness table. The color channel
// returns one item with red, green and blue. Configuration registers are
// written through cfg_we / cfg_index / cfg_data while no item is in flight.
// Throughput is one item per clock while color.ready stays high.
// The datapath is twelve register stages, each holding at most one layer
// of fixed-point multipliers; an accepted item passes through all twelve,
// the last being the color output register.
// Reset clears every stage valid bit and loads the register defaults
// (sun brightness 1.0, all else zero).
// When the receiver stalls, a full stage holds only while every stage after
// it is full, and empty stages keep filling; levels.ready drops only once
// all twelve stages hold an item.
// ---------------------------------------------------------------------------
module lightmap_texel_color import lmtc_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	lmtc_level_if.sink            levels,
	lmtc_color_if.source          color
);

	localparam int F = FRACTION_BITS;
	localparam int W = F + 6;
	localparam int XW = W + Q_W;

	// Conversion of the Q1.15 and Q2.14 registers to the internal format.
	localparam int SHL15 = (F >= 15) ? F - 15 : 0;
	localparam int SHR15 = (F >= 15) ? 0 : 15 - F;
	localparam int SHL14 = (F >= 14) ? F - 14 : 0;
	localparam int SHR14 = (F >= 14) ? 0 : 14 - F;
	localparam logic signed [XW-1:0] RND15  = XW'((64'd1 << SHR15) >> 1);
	localparam logic signed [XW-1:0] RND14  = XW'((64'd1 << SHR14) >> 1);
	localparam logic signed [XW-1:0] RND14N = (RND14 > 0) ? RND14 - 1 : '0;

	localparam logic signed [2*W-1:0] HALF   = (2*W)'(64'd1 << (F - 1));
	localparam logic signed [2*W-1:0] HALF_N = HALF - 1;

	localparam logic signed [W-1:0] ONE  = W'(64'd1 << F);
	localparam logic signed [W-1:0] K095 = W'(((64'd95 << F) + 64'd50) / 64'd100);
	localparam logic signed [W-1:0] K005 = W'(((64'd5 << F) + 64'd50) / 64'd100);
	localparam logic signed [W-1:0] K065 = W'(((64'd65 << F) + 64'd50) / 64'd100);
	localparam logic signed [W-1:0] K035 = W'(((64'd35 << F) + 64'd50) / 64'd100);
	localparam logic signed [W-1:0] K096 = W'(((64'd96 << F) + 64'd50) / 64'd100);
	localparam logic signed [W-1:0] K003 = W'(((64'd3 << F) + 64'd50) / 64'd100);
	localparam logic signed [W-1:0] K075 = W'(((64'd75 << F) + 64'd50) / 64'd100);
	localparam logic signed [W-1:0] K022 = W'(((64'd22 << F) + 64'd50) / 64'd100);
	localparam logic signed [W-1:0] K028 = W'(((64'd28 << F) + 64'd50) / 64'd100);
	localparam logic signed [W-1:0] K025 = W'(((64'd25 << F) + 64'd50) / 64'd100);
	localparam logic signed [W-1:0] K010 = W'(((64'd1 << F) + 64'd5) / 64'd10);
	localparam logic signed [W-1:0] K150 = W'(((64'd15 << F) + 64'd5) / 64'd10);
	localparam logic signed [W-1:0] K060 = W'(((64'd6 << F) + 64'd5) / 64'd10);
	localparam logic signed [W-1:0] K040 = W'(((64'd4 << F) + 64'd5) / 64'd10);

	// Product of two internal values, rounded to nearest, ties away from zero.
	function automatic logic signed [W-1:0] fmul(input logic signed [W-1:0] a,
			input logic signed [W-1:0] b);
		logic signed [2*W-1:0] p;
		p = a * b;
		p = (p < 0) ? p + HALF_N : p + HALF;
		return W'(p >>> F);
	endfunction

	function automatic logic signed [W-1:0] from_q15(input logic [Q_W-1:0] raw);
		logic signed [XW-1:0] v;
		v = $signed({{W{1'b0}}, raw});
		v = (v <<< SHL15) + RND15;
		return W'(v >>> SHR15);
	endfunction

	function automatic logic signed [W-1:0] from_q14s(input logic [Q_W-1:0] raw);
		logic signed [XW-1:0] v;
		v = $signed({{W{raw[Q_W-1]}}, raw});
		v = v <<< SHL14;
		v = (v < 0) ? v + RND14N : v + RND14;
		return W'(v >>> SHR14);
	endfunction

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [Q_W-1:0]               sun_q;
	logic [Q_W-1:0]               gamma_q;
	logic [Q_W-1:0]               flicker_q;
	logic [MODE_W-1:0]            mode_q;
	logic [TABLE_ENTRIES*Q_W-1:0] table_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sun_q     <= SUN_RESET;
			gamma_q   <= '0;
			flicker_q <= '0;
			mode_q    <= '0;
			table_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_SUN:     sun_q <= cfg_data[Q_W-1:0];
				REG_GAMMA:   gamma_q <= cfg_data[Q_W-1:0];
				REG_FLICKER: flicker_q <= cfg_data[Q_W-1:0];
				REG_MODE:    mode_q <= cfg_data[MODE_W-1:0];
				REG_TABLE_A: table_q[0*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
				REG_TABLE_B: table_q[1*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
				REG_TABLE_C: table_q[2*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
				REG_TABLE_D: table_q[3*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	logic signed [W-1:0] sun_i;
	logic signed [W-1:0] gam_i;
	logic signed [W-1:0] omg_i;
	logic signed [W-1:0] tf_i;

	assign sun_i = from_q15(sun_q);
	assign gam_i = from_q15(gamma_q);
	assign omg_i = ONE - gam_i;
	assign tf_i  = from_q14s(flicker_q);

	// ------------------------------------------------------------------
	// Stage control: a stage loads when it is empty or its successor loads.
	// ------------------------------------------------------------------
	logic [NSTAGE-1:0] stage_vld_q;
	logic [NSTAGE:0]   adv;
	logic              in_acc;
	logic              out_acc;

	assign adv[NSTAGE] = color.ready;
	for (genvar i = 0; i < NSTAGE; i++) begin : g_adv
		assign adv[i] = !stage_vld_q[i] || adv[i+1];
	end

	assign levels.ready = adv[0];
	assign in_acc  = levels.valid && levels.ready;
	assign out_acc = color.valid && color.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			for (int i = 0; i < NSTAGE; i++) begin
				if (adv[i]) begin
					stage_vld_q[i] <= (i == 0) ? levels.valid : stage_vld_q[(i == 0) ? 0 : i-1];
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: table lookup and register-derived factors
	// ------------------------------------------------------------------
	logic [Q_W-1:0]      sky_raw;
	logic [Q_W-1:0]      blk_raw;
	logic signed [W-1:0] sky_e_s1, blk_e_s1, sky_fac_s1, sun_mix_s1, tf_fac_s1;

	assign sky_raw = table_q[{levels.sky_level, 4'b0000} +: Q_W];
	assign blk_raw = table_q[{levels.block_level, 4'b0000} +: Q_W];

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			sky_e_s1   <= from_q15(sky_raw);
			blk_e_s1   <= from_q15(blk_raw);
			sky_fac_s1 <= fmul(sun_i, K095) + K005;
			sun_mix_s1 <= fmul(sun_i, K065) + K035;
			tf_fac_s1  <= fmul(tf_i, K010) + K150;
		end
	end

	// Stage 2: sky part (bare entry during a lightning flash) and block part.
	logic signed [W-1:0] sky_part_s2, blk_part_s2, sun_mix_s2;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			sky_part_s2 <= mode_q[MODE_LIGHTNING] ? sky_e_s1 : fmul(sky_e_s1, sky_fac_s1);
			blk_part_s2 <= fmul(blk_e_s1, tf_fac_s1);
			sun_mix_s2  <= sun_mix_s1;
		end
	end

	// Stage 3
	logic signed [W-1:0] sky_sun_s3, bp_g_s3, bp_sq_s3, sky_part_s3, blk_part_s3;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			sky_sun_s3  <= fmul(sky_part_s2, sun_mix_s2);
			bp_g_s3     <= fmul(blk_part_s2, K060) + K040;
			bp_sq_s3    <= fmul(blk_part_s2, blk_part_s2);
			sky_part_s3 <= sky_part_s2;
			blk_part_s3 <= blk_part_s2;
		end
	end

	// Stage 4: factors of the green and blue block curves.
	logic signed [W-1:0] g_fac_s4, b_fac_s4, sky_sun_s4, sky_part_s4, blk_part_s4;

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			g_fac_s4    <= fmul(bp_g_s3, K060) + K040;
			b_fac_s4    <= fmul(bp_sq_s3, K060) + K040;
			sky_sun_s4  <= sky_sun_s3;
			sky_part_s4 <= sky_part_s3;
			blk_part_s4 <= blk_part_s3;
		end
	end

	// Stage 5
	logic signed [W-1:0] blk_green_s5, blk_blue_s5, sky_sun_s5, sky_part_s5, blk_part_s5;

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			blk_green_s5 <= fmul(blk_part_s4, g_fac_s4);
			blk_blue_s5  <= fmul(blk_part_s4, b_fac_s4);
			sky_sun_s5   <= sky_sun_s4;
			sky_part_s5  <= sky_part_s4;
			blk_part_s5  <= blk_part_s4;
		end
	end

	// Stage 6: channel mix, or the end dimension colors.
	logic signed [W-1:0] sum6   [NUM_CH];
	logic signed [W-1:0] endsrc [NUM_CH];
	logic signed [W-1:0] endoff [NUM_CH];
	logic signed [W-1:0] mix6   [NUM_CH];
	logic signed [W-1:0] x_s6   [NUM_CH];

	always_comb begin
		sum6[CH_RED]     = sky_sun_s5 + blk_part_s5;
		sum6[CH_GREEN]   = sky_sun_s5 + blk_green_s5;
		sum6[CH_BLUE]    = sky_part_s5 + blk_blue_s5;
		endsrc[CH_RED]   = blk_part_s5;
		endsrc[CH_GREEN] = blk_green_s5;
		endsrc[CH_BLUE]  = blk_blue_s5;
		endoff[CH_RED]   = K022;
		endoff[CH_GREEN] = K028;
		endoff[CH_BLUE]  = K025;
		for (int c = 0; c < NUM_CH; c++) begin
			mix6[c] = mode_q[MODE_END] ? endoff[c] + fmul(endsrc[c], K075)
				: fmul(sum6[c], K096) + K003;
		end
	end

	// Stages 7 to 12 run one lane per channel.
	logic signed [W-1:0] xc_s7   [NUM_CH];
	logic signed [W-1:0] t_s7    [NUM_CH];
	logic signed [W-1:0] t2_s8   [NUM_CH];
	logic signed [W-1:0] xg_s8   [NUM_CH];
	logic signed [W-1:0] t4_s9   [NUM_CH];
	logic signed [W-1:0] xg_s9   [NUM_CH];
	logic signed [W-1:0] cg_s10  [NUM_CH];
	logic signed [W-1:0] xg_s10  [NUM_CH];
	logic signed [W-1:0] y_s11   [NUM_CH];
	logic signed [W-1:0] yc12    [NUM_CH];
	logic [W+7:0]        prod12  [NUM_CH];
	logic [COLOR_W-1:0]  color_s12 [NUM_CH];

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			if (y_s11[c] < 0) begin
				yc12[c] = '0;
			end else if (y_s11[c] > ONE) begin
				yc12[c] = ONE;
			end else begin
				yc12[c] = y_s11[c];
			end
			// Times 255 as times 256 minus one copy.
			prod12[c] = ({8'b0, yc12[c]} << 8) - {8'b0, yc12[c]};
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < NUM_CH; c++) begin
			if (adv[5]) begin
				x_s6[c] <= mix6[c];
			end
			if (adv[6]) begin
				xc_s7[c] <= (x_s6[c] > ONE) ? ONE : x_s6[c];
				t_s7[c]  <= ONE - ((x_s6[c] > ONE) ? ONE : x_s6[c]);
			end
			if (adv[7]) begin
				t2_s8[c] <= fmul(t_s7[c], t_s7[c]);
				xg_s8[c] <= fmul(xc_s7[c], omg_i);
			end
			if (adv[8]) begin
				t4_s9[c] <= fmul(t2_s8[c], t2_s8[c]);
				xg_s9[c] <= xg_s8[c];
			end
			if (adv[9]) begin
				cg_s10[c] <= fmul(ONE - t4_s9[c], gam_i);
				xg_s10[c] <= xg_s9[c];
			end
			if (adv[10]) begin
				y_s11[c] <= fmul(xg_s10[c] + cg_s10[c], K096) + K003;
			end
			if (adv[11]) begin
				color_s12[c] <= prod12[c][F +: COLOR_W];
			end
		end
	end

	assign color.valid = stage_vld_q[NSTAGE-1];
	assign color.red   = color_s12[CH_RED];
	assign color.green = color_s12[CH_GREEN];
	assign color.blue  = color_s12[CH_BLUE];

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_ready_low_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!levels.ready |-> (&stage_vld_q))
		else $error("input stalled while a stage was empty");

	a_accept_fills_first: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> stage_vld_q[0])
		else $error("accepted item did not reach the first stage");

	a_item_count: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> ($countones(stage_vld_q) ==
			$past($countones(stage_vld_q)) + $past(in_acc) - $past(out_acc)))
		else $error("pipeline lost or duplicated an item");

endmodule

>>> bench/lmtc_texel_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lmtc_texel_checker
// Watches the level and color channels of the lightmap texel color block,
// computes the expected texel of every accepted item from its own copy of
// the registers, and compares each returned texel field by field in order.
// ---------------------------------------------------------------------------
module lmtc_texel_checker import lmtc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	lmtc_level_if                 levels,
	lmtc_color_if                 color,
	output int                    pending,
	output int                    mismatch_count
);

	localparam int FRAC = FRACTION_BITS_DEF;

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} texel_t;

	function automatic longint fix_const(longint num, longint den);
		return ((num <<< FRAC) + den / 2) / den;
	endfunction

	localparam longint ONE   = longint'(1) <<< FRAC;
	localparam longint C_095 = fix_const(95, 100);
	localparam longint C_005 = fix_const(5, 100);
	localparam longint C_065 = fix_const(65, 100);
	localparam longint C_035 = fix_const(35, 100);
	localparam longint C_010 = fix_const(1, 10);
	localparam longint C_150 = fix_const(15, 10);
	localparam longint C_060 = fix_const(6, 10);
	localparam longint C_040 = fix_const(4, 10);
	localparam longint C_096 = fix_const(96, 100);
	localparam longint C_003 = fix_const(3, 100);
	localparam longint C_022 = fix_const(22, 100);
	localparam longint C_028 = fix_const(28, 100);
	localparam longint C_025 = fix_const(25, 100);
	localparam longint C_075 = fix_const(75, 100);

	logic [Q_W-1:0]        sun_q;
	logic [Q_W-1:0]        gamma_q;
	logic [Q_W-1:0]        flicker_q;
	logic [MODE_W-1:0]     mode_q;
	logic [CFG_DATA_W-1:0] table_q [4];

	texel_t expected_texels [$];

	// Shift right with rounding to nearest; ties move away from zero.
	function automatic longint round_shift(longint v, int s);
		longint m;
		if (s == 0) return v;
		m = (v < 0) ? -v : v;
		m = (m + (longint'(1) <<< (s - 1))) >>> s;
		return (v < 0) ? -m : m;
	endfunction

	function automatic longint to_q(longint v, int src_frac);
		if (FRAC >= src_frac) return v <<< (FRAC - src_frac);
		return round_shift(v, src_frac - FRAC);
	endfunction

	function automatic longint qmul(longint a, longint b);
		return round_shift(a * b, FRAC);
	endfunction

	function automatic longint brightness(logic [LEVEL_W-1:0] idx);
		logic [Q_W-1:0] raw;
		raw = table_q[idx[3:2]][idx[1:0] * Q_W +: Q_W];
		return to_q(longint'(raw), 15);
	endfunction

	// Clamp, blend with the fourth-power gamma curve, rescale and quantize.
	function automatic logic [COLOR_W-1:0] quantize_channel(longint x, longint gam);
		longint clip, t, t2, curved, y;
		clip = (x > ONE) ? ONE : x;
		t = ONE - clip;
		t2 = qmul(t, t);
		curved = ONE - qmul(t2, t2);
		y = qmul(clip, ONE - gam) + qmul(curved, gam);
		y = qmul(y, C_096) + C_003;
		if (y > ONE) y = ONE;
		if (y < 0) y = 0;
		return COLOR_W'((y * 255) >>> FRAC);
	endfunction

	function automatic texel_t texel_from_levels(logic [LEVEL_W-1:0] sky,
			logic [LEVEL_W-1:0] blk);
		longint sun, gam, tf, sky_e, blk_e, sky_scale, sun_mix;
		longint sky_part, blk_part, blk_green, blk_blue, sky_sun, r, g, b;
		texel_t t;
		sun = to_q(longint'(sun_q), 15);
		gam = to_q(longint'(gamma_q), 15);
		tf = to_q(longint'($signed(flicker_q)), 14);
		sky_e = brightness(sky);
		blk_e = brightness(blk);
		sky_scale = qmul(sun, C_095) + C_005;
		sun_mix = qmul(sun, C_065) + C_035;
		// A lightning flash bypasses the sun scaling of the sky part.
		sky_part = mode_q[MODE_LIGHTNING] ? sky_e : qmul(sky_e, sky_scale);
		blk_part = qmul(blk_e, qmul(tf, C_010) + C_150);
		sky_sun = qmul(sky_part, sun_mix);
		blk_green = qmul(blk_part, qmul(qmul(blk_part, C_060) + C_040, C_060) + C_040);
		blk_blue = qmul(blk_part, qmul(qmul(blk_part, blk_part), C_060) + C_040);
		r = qmul(sky_sun + blk_part, C_096) + C_003;
		g = qmul(sky_sun + blk_green, C_096) + C_003;
		b = qmul(sky_part + blk_blue, C_096) + C_003;
		if (mode_q[MODE_END]) begin
			r = C_022 + qmul(blk_part, C_075);
			g = C_028 + qmul(blk_green, C_075);
			b = C_025 + qmul(blk_blue, C_075);
		end
		t.red = quantize_channel(r, gam);
		t.green = quantize_channel(g, gam);
		t.blue = quantize_channel(b, gam);
		return t;
	endfunction

	task automatic check_field(string name, logic [COLOR_W-1:0] want,
			logic [COLOR_W-1:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	initial begin
		pending = 0;
		mismatch_count = 0;
	end

	always @(posedge clk or negedge arst_n) begin : watch
		texel_t want;
		if (!arst_n) begin
			sun_q = SUN_RESET;
			gamma_q = '0;
			flicker_q = '0;
			mode_q = '0;
			for (int i = 0; i < 4; i++) table_q[i] = '0;
			expected_texels.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_SUN: sun_q = cfg_data[Q_W-1:0];
					REG_GAMMA: gamma_q = cfg_data[Q_W-1:0];
					REG_FLICKER: flicker_q = cfg_data[Q_W-1:0];
					REG_MODE: mode_q = cfg_data[MODE_W-1:0];
					REG_TABLE_A: table_q[0] = cfg_data;
					REG_TABLE_B: table_q[1] = cfg_data;
					REG_TABLE_C: table_q[2] = cfg_data;
					REG_TABLE_D: table_q[3] = cfg_data;
					default: ;
				endcase
			end
			if (color.valid && color.ready) begin
				if (expected_texels.size() == 0) begin
					$error("texel returned with no item outstanding: %0d %0d %0d",
						color.red, color.green, color.blue);
					mismatch_count++;
				end else begin
					want = expected_texels.pop_front();
					check_field("red", want.red, color.red);
					check_field("green", want.green, color.green);
					check_field("blue", want.blue, color.blue);
				end
			end
			if (levels.valid && levels.ready)
				expected_texels.push_back(texel_from_levels(levels.sky_level,
					levels.block_level));
		end
		pending = expected_texels.size();
	end

endmodule

>>> bench/lightmap_texel_color_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lightmap_texel_color_test
// Drives light level items into the lightmap texel color block through a
// series of register settings, directed corners first and then random
// ones, with bursty input and a stalling receiver; the checker beside the
// block predicts and compares every texel.
// ---------------------------------------------------------------------------
module lightmap_texel_color_test;
	import lmtc_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_PHASES = 16;
	localparam int PHASE_ITEMS   = 50;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    pending;
	int                    mismatch_count;
	int                    cycle_count = 0;
	int                    burst_left = 0;

	logic [Q_W-1:0]        sun_v;
	logic [Q_W-1:0]        gamma_v;
	logic [Q_W-1:0]        flicker_v;
	logic [MODE_W-1:0]     mode_v;
	logic [CFG_DATA_W-1:0] table_v [4];

	lmtc_level_if level_ch ();
	lmtc_color_if color_ch ();

	lightmap_texel_color dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.levels(level_ch),
		.color(color_ch)
	);

	lmtc_texel_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.levels(level_ch),
		.color(color_ch),
		.pending(pending),
		.mismatch_count(mismatch_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// The receiver switches between free flow, coin flips, a fixed
	// duty pattern and occasional long stalls.
	initial begin : color_stall
		int pattern;
		int pattern_left;
		int stall_left;
		int tick;
		pattern = 0;
		pattern_left = 0;
		stall_left = 0;
		tick = 0;
		color_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (pattern_left == 0) begin
				pattern = $urandom_range(0, 3);
				pattern_left = $urandom_range(32, 200);
			end
			pattern_left--;
			tick++;
			case (pattern)
				0: color_ch.ready <= 1'b1;
				1: color_ch.ready <= 1'($urandom_range(0, 1));
				2: color_ch.ready <= (tick % 7) < 4;
				default: begin
					if (stall_left > 0) begin
						stall_left--;
						color_ch.ready <= 1'b0;
					end else if ($urandom_range(0, 30) == 0) begin
						stall_left = $urandom_range(5, 20);
						color_ch.ready <= 1'b0;
					end else begin
						color_ch.ready <= 1'b1;
					end
				end
			endcase
		end
	end

	function automatic logic [MODE_W-1:0] mode_bits(bit lightning, bit end_dim);
		logic [MODE_W-1:0] m;
		m = '0;
		m[MODE_LIGHTNING] = lightning;
		m[MODE_END] = end_dim;
		return m;
	endfunction

	function automatic logic [Q_W-1:0] rand_unit();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return 16'h8000;
			2: return 16'hFFFF;
			3: return Q_W'($urandom);
			default: return Q_W'($urandom_range(0, 32768));
		endcase
	endfunction

	function automatic logic [LEVEL_W-1:0] rand_level();
		if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 4'hF : 4'h0;
		return LEVEL_W'($urandom);
	endfunction

	task automatic set_entry(int e, logic [Q_W-1:0] v);
		table_v[e / 4][(e % 4) * Q_W +: Q_W] = v;
	endtask

	task automatic put_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] d);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_data <= d;
		@(posedge clk);
	endtask

	task automatic load_setting();
		put_reg(REG_SUN, CFG_DATA_W'(sun_v));
		put_reg(REG_GAMMA, CFG_DATA_W'(gamma_v));
		put_reg(REG_FLICKER, CFG_DATA_W'(flicker_v));
		put_reg(REG_MODE, CFG_DATA_W'(mode_v));
		put_reg(REG_TABLE_A, table_v[0]);
		put_reg(REG_TABLE_B, table_v[1]);
		put_reg(REG_TABLE_C, table_v[2]);
		put_reg(REG_TABLE_D, table_v[3]);
		cfg_we <= 1'b0;
	endtask

	task automatic send_levels(logic [LEVEL_W-1:0] sky, logic [LEVEL_W-1:0] blk);
		if (burst_left == 0) begin
			level_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 10);
		end
		level_ch.valid <= 1'b1;
		level_ch.sky_level <= sky;
		level_ch.block_level <= blk;
		@(posedge clk);
		while (!level_ch.ready) @(posedge clk);
		burst_left--;
	endtask

	// Leaves the block empty so that the registers may be rewritten.
	task automatic drain_items();
		level_ch.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);
	endtask

	task automatic ramp_table();
		for (int e = 0; e < TABLE_ENTRIES; e++) set_entry(e, Q_W'(e * 2184));
	endtask

	task automatic random_table();
		for (int e = 0; e < TABLE_ENTRIES; e++) set_entry(e, rand_unit());
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_SUN;
		cfg_data = '0;
		level_ch.valid = 1'b0;
		level_ch.sky_level = '0;
		level_ch.block_level = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Register defaults straight out of reset.
		send_levels(4'h0, 4'h0);
		send_levels(4'hF, 4'hF);
		send_levels(4'h7, 4'h3);
		drain_items();

		// Plain day light on a ramp table.
		sun_v = 16'h8000;
		gamma_v = '0;
		flicker_v = '0;
		mode_v = mode_bits(1'b0, 1'b0);
		ramp_table();
		load_setting();
		send_levels(4'h0, 4'hF);
		send_levels(4'hF, 4'h0);
		send_levels(4'hF, 4'hF);
		send_levels(4'h0, 4'h0);
		drain_items();

		// Lightning flash at night, full gamma, most negative flicker, and a
		// saturated table so the clamps engage.
		sun_v = '0;
		gamma_v = 16'h8000;
		flicker_v = 16'h8000;
		mode_v = mode_bits(1'b1, 1'b0);
		for (int e = 0; e < TABLE_ENTRIES; e++) set_entry(e, 16'hFFFF);
		load_setting();
		send_levels(4'hF, 4'hF);
		send_levels(4'h0, 4'h0);
		send_levels(4'h5, 4'h9);
		drain_items();

		// End dimension coloring with the largest positive flicker.
		sun_v = 16'h8000;
		gamma_v = 16'h8000;
		flicker_v = 16'h7FFF;
		mode_v = mode_bits(1'b0, 1'b1);
		ramp_table();
		load_setting();
		send_levels(4'h0, 4'hF);
		send_levels(4'hF, 4'h0);
		send_levels(4'hA, 4'h5);
		send_levels(4'h5, 4'hA);
		drain_items();

		// Both overrides, with the sun register above 1.0.
		sun_v = 16'hFFFF;
		gamma_v = 16'h4000;
		flicker_v = 16'h4000;
		mode_v = mode_bits(1'b1, 1'b1);
		random_table();
		load_setting();
		send_levels(4'hF, 4'hF);
		send_levels(4'h0, 4'h0);
		send_levels(4'h3, 4'hC);
		send_levels(4'hC, 4'h3);
		drain_items();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			sun_v = rand_unit();
			gamma_v = rand_unit();
			case ($urandom_range(0, 5))
				0: flicker_v = 16'h8000;
				1: flicker_v = 16'h7FFF;
				default: flicker_v = Q_W'($urandom);
			endcase
			mode_v = mode_bits(p[0], p[1]);
			random_table();
			load_setting();
			repeat (PHASE_ITEMS) send_levels(rand_level(), rand_level());
			drain_items();
		end

		repeat (16) @(posedge clk);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
